>>> design/prefix_function_stream_macros.svh
// Assertion helpers for the prefix function stream
`ifndef PREFIX_FUNCTION_STREAM_MACROS_SVH
`define PREFIX_FUNCTION_STREAM_MACROS_SVH

`ifndef SYNTH
// checked only out of reset
`define PFS_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// checked at every edge, reset included
`define PFS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PFS_ASSERT(name, clk, rstn, prop, msg)
`define PFS_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

>>> design/pfs_pkg.sv
package pfs_pkg;

  localparam int unsigned MAX_LEN_DEF = 1024;
  localparam int unsigned BORDER_W    = 10;

  typedef struct packed {
    logic [7:0] symbol;
    logic       start_req;
  } in_t;

  typedef struct packed {
    logic [BORDER_W-1:0] border_len;
    logic                overflow;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD_J,
    ST_WALK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic take_in;
    logic load_j;
    logic step;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_short;
    logic walk_done;
    logic out_free;
  } status_t;

endpackage

>>> design/prefix_function_stream.sv
// Online KMP prefix function over a byte stream. Each accepted symbol yields one
// result: the longest proper border of the prefix so far, or overflow once the
// string holds MAX_LEN symbols (border 0 until the next start_req). A symbol
// that begins a string, or arrives past capacity, goes from the accepting state
// straight to the emit state, which loads its result into the output register;
// any other passes through load, a walk of k fallback steps and a commit, then
// emit, each fallback step a read through the single read port of the symbol and
// border memories. Fallbacks total at most the string length. The next symbol is
// accepted once the result sits in the output register, even while it waits to
// be taken. The memories need no clearing after reset.
module prefix_function_stream #(
  parameter int unsigned MAX_LEN = pfs_pkg::MAX_LEN_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pfs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pfs_pkg::out_t out_data_o
);
  import pfs_pkg::*;

  cmd_t    cmd;
  status_t status;

  pfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pfs_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> design/pfs_ctrl.sv
`include "prefix_function_stream_macros.svh"

module pfs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pfs_pkg::status_t  status_i,
  output pfs_pkg::cmd_t     cmd_o
);
  import pfs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d = status_i.in_short ? ST_EMIT : ST_LOAD_J;
        end
      end
      ST_LOAD_J: begin
        cmd_o.load_j = 1'b1;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (status_i.walk_done) begin
          cmd_o.commit = 1'b1;
          state_d = ST_EMIT;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `PFS_ASSERT_ALWAYS(a_cmd_onehot, clk_i, $onehot0(cmd_o), "more than one datapath command")
  `PFS_ASSERT(a_commit_emit, clk_i, rst_ni, cmd_o.commit |=> state_q == ST_EMIT,
              "commit not followed by emit state")
  `PFS_ASSERT(a_walk_start, clk_i, rst_ni, (cmd_o.take_in && !status_i.in_short) |=> cmd_o.load_j,
              "walk did not start after accepted symbol")

endmodule

>>> design/pfs_dp.sv
`include "prefix_function_stream_macros.svh"

module pfs_dp #(
  parameter int unsigned MAX_LEN = pfs_pkg::MAX_LEN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfs_pkg::in_t      in_data_i,
  input  pfs_pkg::cmd_t     cmd_i,
  output pfs_pkg::status_t  status_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output pfs_pkg::out_t     out_data_o
);
  import pfs_pkg::*;

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned PW = $clog2(MAX_LEN + 1);

  logic [7:0]    text_mem [MAX_LEN];
  logic [AW-1:0] bord_mem [MAX_LEN];

  logic [PW-1:0] pos_q;
  logic          ovf_q;
  logic [7:0]    sym_q;
  logic [AW-1:0] j_q;
  out_t          res_q;
  logic          out_valid_q;
  out_t          out_q;
  logic [7:0]    t_rdata_q;
  logic [AW-1:0] b_rdata_q;

  logic [PW-1:0] pos_eff;
  logic          ovf_eff;
  logic          full;
  logic [PW-1:0] lim;
  logic [AW-1:0] jn;
  logic          match;
  logic [AW-1:0] final_j;
  logic [31:0]   final_ext;
  logic [AW-1:0] t_raddr;
  logic [AW-1:0] b_raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wtext;
  logic [AW-1:0] wbord;

  always_comb begin
    pos_eff   = in_data_i.start_req ? '0 : pos_q;
    ovf_eff   = in_data_i.start_req ? 1'b0 : ovf_q;
    full      = ovf_eff || (pos_eff >= PW'(MAX_LEN));
    lim       = cmd_i.load_j ? pos_q : PW'(j_q);
    jn        = (PW'(b_rdata_q) >= lim) ? '0 : b_rdata_q;
    match     = (t_rdata_q == sym_q);
    final_j   = j_q + AW'(match);
    final_ext = 32'(final_j);

    status_o.in_short  = full || (pos_eff == '0);
    status_o.walk_done = (j_q == '0) || match;
    status_o.out_free  = !out_valid_q || !out_stall_i;

    t_raddr = jn;
    if (cmd_i.take_in) begin
      b_raddr = (pos_q == '0) ? '0 : AW'(pos_q - PW'(1));
    end else begin
      b_raddr = (jn == '0) ? '0 : jn - AW'(1);
    end

    we    = (cmd_i.take_in && !full && (pos_eff == '0)) || cmd_i.commit;
    waddr = cmd_i.commit ? pos_q[AW-1:0] : '0;
    wtext = cmd_i.commit ? sym_q : in_data_i.symbol;
    wbord = cmd_i.commit ? final_j : '0;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      text_mem[waddr] <= wtext;
      bord_mem[waddr] <= wbord;
    end
    t_rdata_q <= text_mem[t_raddr];
    b_rdata_q <= bord_mem[b_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take_in) begin
        if (full) begin
          pos_q <= pos_eff;
          ovf_q <= 1'b1;
        end else if (pos_eff == '0) begin
          pos_q <= PW'(1);
          ovf_q <= 1'b0;
        end
      end else if (cmd_i.commit) begin
        pos_q <= pos_q + PW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      sym_q            <= in_data_i.symbol;
      res_q.border_len <= '0;
      res_q.overflow   <= full;
    end
    if (cmd_i.load_j || cmd_i.step) begin
      j_q <= jn;
    end
    if (cmd_i.commit) begin
      res_q.border_len <= final_ext[BORDER_W-1:0];
      res_q.overflow   <= 1'b0;
    end
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PFS_ASSERT(a_pos_range, clk_i, rst_ni, pos_q <= PW'(MAX_LEN), "position beyond capacity")
  `PFS_ASSERT(a_j_below_pos, clk_i, rst_ni, (cmd_i.step || cmd_i.commit) |-> (PW'(j_q) < pos_q),
              "border candidate not below position")
  `PFS_ASSERT(a_emit_load, clk_i, rst_ni, cmd_i.emit |=> (out_valid_q && out_q == $past(res_q)),
              "result not loaded into output register")

endmodule

>>> tb/prefix_function_stream_tb.sv
`timescale 1ns / 100ps

module prefix_function_stream_tb;

  localparam int unsigned CAPACITY    = pfs_pkg::MAX_LEN_DEF;
  localparam int unsigned LIMIT       = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned RAND_ITEMS  = 400;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid;
  logic          in_stall;
  pfs_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  pfs_pkg::out_t out_data;

  // predictor state
  logic [7:0]    sym_mem [CAPACITY];
  int unsigned   brd_mem [CAPACITY];
  int unsigned   str_len;
  logic          str_over;

  pfs_pkg::out_t expected_borders [$];
  int unsigned   fail_cnt;
  int unsigned   mismatch_cnt;
  int unsigned   cycle_cnt;
  int unsigned   burst_left;
  bit            idle_on;
  bit            hold_req;

  prefix_function_stream #(
    .MAX_LEN(CAPACITY)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic pfs_pkg::out_t next_border(pfs_pkg::in_t item);
    pfs_pkg::out_t res;
    int unsigned   j;
    int unsigned   nj;
    res = '0;
    if (item.start_req) begin
      str_len  = 0;
      str_over = 1'b0;
    end
    if (str_over || str_len >= CAPACITY) begin
      str_over     = 1'b1;
      res.overflow = 1'b1;
      return res;
    end
    if (str_len == 0) begin
      sym_mem[0] = item.symbol;
      brd_mem[0] = 0;
      str_len    = 1;
      return res;
    end
    j = brd_mem[str_len-1];
    if (j >= str_len) begin
      j = 0;
    end
    while (j > 0 && sym_mem[j] != item.symbol) begin
      nj = brd_mem[j-1];
      j  = (nj < j) ? nj : 0;
    end
    if (sym_mem[j] == item.symbol) begin
      j++;
    end
    sym_mem[str_len] = item.symbol;
    brd_mem[str_len] = j;
    str_len++;
    res.border_len = j[pfs_pkg::BORDER_W-1:0];
    return res;
  endfunction

  task automatic sender_idle(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
  endtask

  // one transaction, then the burst/gap pacing
  task automatic send_symbol(input logic [7:0] sym, input logic start);
    pfs_pkg::in_t item;
    item.symbol    = sym;
    item.start_req = start;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    expected_borders.push_back(next_border(item));
    @(negedge clk_i);
    in_valid <= 1'b0;
    if (idle_on) begin
      if (burst_left == 0) begin
        sender_idle($urandom_range(6, 1));
        burst_left = $urandom_range(12, 1);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_results();
    while (expected_borders.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    idle_on = 1'b0;
    send_symbol(8'hFF, 1'b0);  // first after reset, no start flag
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'hFF, 1'b0);
    idle_on = 1'b1;
    send_symbol(8'h00, 1'b1);
    send_symbol(8'h00, 1'b1);  // restart right after a one-symbol string
    send_symbol(8'h5A, 1'b1);
    send_symbol(8'h5A, 1'b0);
    send_symbol(8'hA5, 1'b0);
    send_symbol(8'h5A, 1'b0);
    send_symbol(8'h5A, 1'b0);
    send_symbol(8'h5A, 1'b0);  // falls back
    send_symbol(8'hA5, 1'b0);
    send_symbol(8'h00, 1'b0);  // falls back to zero
    send_symbol(8'h5A, 1'b0);
    drain_results();
  endtask

  task automatic test_backpressure();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    send_symbol(8'h3C, 1'b1);
    repeat (23) send_symbol($urandom_range(1, 0) ? 8'h3C : 8'hC3, 1'b0);
    while (hold_req) @(posedge clk_i);
    drain_results();
  endtask

  task automatic test_capacity();
    logic [7:0] fill;
    fill    = 8'($urandom_range(255, 0));
    idle_on = 1'b0;
    send_symbol(fill, 1'b1);
    repeat (CAPACITY - 1) send_symbol(fill, 1'b0);
    idle_on = 1'b1;
    repeat (5) send_symbol(8'($urandom_range(255, 0)), 1'b0);
    send_symbol(fill, 1'b1);
    send_symbol(fill, 1'b0);
    idle_on = 1'b0;
    send_symbol(fill, 1'b1);
    repeat (CAPACITY - 1) send_symbol($urandom_range(1, 0) ? fill : ~fill, 1'b0);
    send_symbol(fill, 1'b0);
    send_symbol(~fill, 1'b1);
    drain_results();
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned len;
    int unsigned asz;
    int unsigned wlen;
    bit          periodic;
    logic [7:0]  alph [3];
    logic [7:0]  word [8];
    logic [7:0]  sym;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      idle_on = ($urandom_range(3, 0) != 0);
      if ($urandom_range(4, 0) != 0) begin
        asz      = $urandom_range(3, 1);
        len      = $urandom_range(48, 1);
        wlen     = $urandom_range(8, 1);
        periodic = 1'($urandom_range(1, 0));
        foreach (alph[i]) alph[i] = 8'($urandom_range(255, 0));
        foreach (word[i]) word[i] = alph[$urandom_range(asz - 1, 0)];
        for (int unsigned i = 0; i < len; i++) begin
          sym = periodic ? word[i % wlen] : alph[$urandom_range(asz - 1, 0)];
          if ($urandom_range(15, 0) == 0) begin
            sym = alph[$urandom_range(asz - 1, 0)];
          end
          send_symbol(sym, i == 0);
          sent++;
        end
      end else begin
        repeat ($urandom_range(8, 1)) begin
          send_symbol(8'($urandom_range(255, 0)), $urandom_range(7, 0) == 0);
          sent++;
        end
      end
      if ($urandom_range(19, 0) == 0) begin
        drain_results();
      end
    end
  endtask

  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned k;
    k = 0;
    forever begin
      mode = $urandom_range(3, 0);
      span = $urandom_range(80, 10);
      repeat (span) begin
        @(negedge clk_i);
        if (hold_req) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk_i);
          hold_req = 1'b0;
        end
        k++;
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(3, 0) == 0);
          end
          2: begin
            out_stall <= ($urandom_range(3, 0) != 0);
          end
          default: begin
            out_stall <= (k % 3 != 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_borders
    pfs_pkg::out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_borders.size() == 0) begin
        fail_cnt++;
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected transaction: border_len=%0d overflow=%0b",
                   out_data.border_len, out_data.overflow);
        end
      end else begin
        want = expected_borders.pop_front();
        if (out_data.border_len !== want.border_len ||
            out_data.overflow !== want.overflow) begin
          fail_cnt++;
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: border_len exp %0d got %0d, overflow exp %0b got %0b",
                     want.border_len, out_data.border_len,
                     want.overflow, out_data.overflow);
          end
        end
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("** prefix_function_stream: FAILED **");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    str_len      = 0;
    str_over     = 1'b0;
    fail_cnt     = 0;
    mismatch_cnt = 0;
    burst_left   = 0;
    idle_on      = 1'b0;
    hold_req     = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_capacity();
    test_random();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && expected_borders.size() == 0) begin
      $display("** prefix_function_stream: PASSED **");
    end else begin
      $display("** prefix_function_stream: FAILED **");
    end
    $finish;
  end

endmodule
